>>> src/stereo_to_surround_upmix_assert.svh
// assertion helpers shared by the upmix rtl
`ifndef STEREO_TO_SURROUND_UPMIX_ASSERT_SVH
`define STEREO_TO_SURROUND_UPMIX_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STSU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("upmix check failed");

// next-cycle implication, checked out of reset
`define STSU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("upmix check failed");

`endif

>>> src/stsu_pkg.sv
// ------------------------------------------------------------------
// stsu_pkg
// shared types and q31 constants of the stereo to surround upmixer
// ------------------------------------------------------------------
package stsu_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_GAIN   = 2'd0;
    localparam logic [1:0] CFG_MODE   = 2'd1;
    localparam logic [1:0] CFG_ENABLE = 2'd2;

    localparam logic [30:0] GAIN_RESET = 31'd1354970581;

    // q31 constants, rounded to nearest
    localparam logic signed [31:0] Q31_LIMIT     = 32'sd2145336164;
    localparam logic signed [31:0] Q31_GAIN_M2DB = 32'sd1705806895;
    localparam logic signed [31:0] HPF_B0 = 32'sd710028503;
    localparam logic signed [31:0] HPF_B1 = -32'sd1420057006;
    localparam logic signed [31:0] HPF_B2 = 32'sd710028503;
    localparam logic signed [31:0] HPF_A1 = -32'sd1256424982;
    localparam logic signed [31:0] HPF_A2 = 32'sd509947206;
    localparam logic signed [31:0] LPF_B0 = 32'sd3214468;
    localparam logic signed [31:0] LPF_B1 = 32'sd6428936;
    localparam logic signed [31:0] LPF_B2 = 32'sd3214468;
    localparam logic signed [31:0] LPF_A1 = -32'sd1974736625;
    localparam logic signed [31:0] LPF_A2 = 32'sd913892098;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clear;
        logic acc_sub;
    } t_mac_ctl;

endpackage

>>> src/stsu_mac.sv
// ------------------------------------------------------------------
// stsu_mac
// shared fract multiplier with saturation and a wrapping accumulator
// ------------------------------------------------------------------
module stsu_mac #(
    parameter int SAMPLE_BITS = 32,
    parameter int GUARD_BITS  = 8
) (
    input  logic                                      i_clk,
    input  logic signed [SAMPLE_BITS-1:0]             i_a,
    input  logic signed [SAMPLE_BITS-1:0]             i_b,
    input  stsu_pkg::t_mac_ctl                        i_ctl,
    output logic signed [SAMPLE_BITS-1:0]             o_prod,
    output logic signed [SAMPLE_BITS+GUARD_BITS-1:0]  o_acc
);
    import stsu_pkg::*;

    localparam int W = SAMPLE_BITS;
    localparam int F = SAMPLE_BITS - 1;
    localparam int A = SAMPLE_BITS + GUARD_BITS;

    logic signed [2*W-1:0] full;
    logic signed [W-1:0]   n_prod;
    logic signed [W-1:0]   r_prod;
    logic signed [A-1:0]   base;
    logic signed [A-1:0]   addend;
    logic signed [A-1:0]   n_acc;
    logic signed [A-1:0]   r_acc;

    always_comb begin
        full = i_a * i_b;
        // floor to F fraction bits, then saturate
        if (full[2*W-1] != full[2*W-2]) begin
            n_prod = full[2*W-1] ? {1'b1, {F{1'b0}}} : {1'b0, {F{1'b1}}};
        end else begin
            n_prod = full[2*W-2:F];
        end
        base   = i_ctl.acc_clear ? '0 : r_acc;
        addend = A'(r_prod);
        n_acc  = i_ctl.acc_sub ? base - addend : base + addend;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

>>> src/stereo_to_surround_upmix.sv
// ------------------------------------------------------------------
// stereo_to_surround_upmix
// stereo sample pair in, six surround channels out
// ------------------------------------------------------------------
// input channel: i_valid / o_stall with i_left_in, i_right_in; a beat
// is taken when i_valid is high and o_stall low
// output channel: o_valid / i_stall with six channel samples; a beat
// leaves when o_valid is high and i_stall low
// one shared multiplier and accumulator runs 14 products per beat under
// a 16-step sequencer; the input takes a new beat only after the
// sequencer has finished the last one; a pass-through beat (processing
// disabled) starts on the last step and skips the products
// o_stall is high while the sequencer runs; a finished beat waits in the
// output register, so the next beat can be taken while the receiver
// stalls, and the sequencer holds on its last step until the output
// register frees up
// reset clears filter histories, loads default gain, mode 2_2_0 and
// processing on; config writes go straight into the registers
// ------------------------------------------------------------------
module stereo_to_surround_upmix #(
    parameter int SAMPLE_BITS = 32,
    parameter int GUARD_BITS  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_left_in,
    input  logic signed [31:0] i_right_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_left_out,
    output logic signed [31:0] o_right_out,
    output logic signed [31:0] o_left_surround_out,
    output logic signed [31:0] o_right_surround_out,
    output logic signed [31:0] o_center_out,
    output logic signed [31:0] o_lfe_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);
    import stsu_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int F  = SAMPLE_BITS - 1;
    localparam int A  = SAMPLE_BITS + GUARD_BITS;
    localparam int IO = 32 - SAMPLE_BITS;

    localparam logic signed [W-1:0] FMAX = {1'b0, {F{1'b1}}};
    localparam logic signed [W-1:0] FMIN = {1'b1, {F{1'b0}}};

    localparam logic signed [W-1:0] K_LIMIT = W'(Q31_LIMIT >>> IO);
    localparam logic signed [W-1:0] K_G2    = W'(Q31_GAIN_M2DB >>> IO);
    localparam logic signed [W-1:0] K_HB0 = W'(HPF_B0 >>> IO);
    localparam logic signed [W-1:0] K_HB1 = W'(HPF_B1 >>> IO);
    localparam logic signed [W-1:0] K_HB2 = W'(HPF_B2 >>> IO);
    localparam logic signed [W-1:0] K_HA1 = W'(HPF_A1 >>> IO);
    localparam logic signed [W-1:0] K_HA2 = W'(HPF_A2 >>> IO);
    localparam logic signed [W-1:0] K_LB0 = W'(LPF_B0 >>> IO);
    localparam logic signed [W-1:0] K_LB1 = W'(LPF_B1 >>> IO);
    localparam logic signed [W-1:0] K_LB2 = W'(LPF_B2 >>> IO);
    localparam logic signed [W-1:0] K_LA1 = W'(LPF_A1 >>> IO);
    localparam logic signed [W-1:0] K_LA2 = W'(LPF_A2 >>> IO);

    localparam logic signed [A-1:0] LIM_HI = A'(K_LIMIT);
    localparam logic signed [A-1:0] LIM_LO = -A'(K_LIMIT);

    typedef enum logic [3:0] {
        S_MUL_LO, S_MUL_RO, S_MUL_SL, S_MUL_SR,
        S_HB0, S_HB1, S_HB2, S_HA1, S_HA2,
        S_LB0, S_LB1, S_LB2, S_LA1, S_LA2,
        S_LACC, S_DONE
    } t_step;

    // config and control
    logic [30:0] r_gain;
    logic [1:0]  r_mode;
    logic        r_enable;
    logic        r_busy;
    logic        r_byp;
    logic        r_ov;
    t_step       r_step;
    t_step       n_step;

    // filter histories
    logic signed [W-1:0] r_hx0, r_hx1, r_hy0, r_hy1;
    logic signed [W-1:0] r_lx0, r_lx1, r_ly0, r_ly1;

    // per-beat payload
    logic signed [31:0]  r_lin, r_rin;
    logic signed [W-1:0] r_lo, r_ro, r_sl, r_sr, r_hx, r_rs, r_c, r_lx, r_ls;
    logic signed [31:0]  r_o_l, r_o_r, r_o_ls, r_o_rs, r_o_c, r_o_lfe;

    logic                in_acc;
    logic                can_out;
    logic                fin;
    t_mac_ctl            ctl;
    logic signed [W-1:0] op_a, op_b;
    logic signed [W-1:0] prod;
    logic signed [A-1:0] acc;
    logic signed [A-1:0] acc_shl;
    logic signed [W-1:0] y_sat;
    logic signed [A-1:0] c_sum, l_dif;
    logic signed [W-1:0] c_lim, l_lim;
    logic signed [W-1:0] r_in_s, gain_op;

    assign in_acc  = i_valid && !r_busy;
    assign can_out = !r_ov || !i_stall;
    assign fin     = r_busy && (r_step == S_DONE) && can_out;
    assign o_stall = r_busy;
    assign n_step  = t_step'(r_step + 4'd1);

    assign r_in_s  = r_rin[31:IO];
    assign gain_op = $signed({1'b0, r_gain[30:IO]});

    always_comb begin
        ctl.mul_en    = r_busy && (r_step <= S_LA2);
        ctl.acc_en    = r_busy && (r_step >= S_HB1) && (r_step <= S_LACC);
        ctl.acc_clear = (r_step == S_HB1) || (r_step == S_LB1);
        ctl.acc_sub   = (r_step == S_HA2) || (r_step == S_LB0) ||
                        (r_step == S_LA2) || (r_step == S_LACC);
        unique case (r_step)
            S_MUL_LO: begin op_a = r_lin[31:IO];   op_b = gain_op; end
            S_MUL_RO: begin op_a = r_in_s;         op_b = gain_op; end
            S_MUL_SL: begin op_a = r_lo >>> 2;     op_b = K_G2;    end
            S_MUL_SR: begin op_a = r_ro >>> 2;     op_b = K_G2;    end
            S_HB0:    begin op_a = r_hx;           op_b = K_HB0;   end
            S_HB1:    begin op_a = r_hx0;          op_b = K_HB1;   end
            S_HB2:    begin op_a = r_hx1;          op_b = K_HB2;   end
            S_HA1:    begin op_a = r_hy0;          op_b = K_HA1;   end
            S_HA2:    begin op_a = r_hy1;          op_b = K_HA2;   end
            S_LB0:    begin op_a = r_lx;           op_b = K_LB0;   end
            S_LB1:    begin op_a = r_lx0;          op_b = K_LB1;   end
            S_LB2:    begin op_a = r_lx1;          op_b = K_LB2;   end
            S_LA1:    begin op_a = r_ly0;          op_b = K_LA1;   end
            S_LA2:    begin op_a = r_ly1;          op_b = K_LA2;   end
            default:  begin op_a = '0;             op_b = '0;      end
        endcase
    end

    stsu_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .GUARD_BITS  (GUARD_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_a    (op_a),
        .i_b    (op_b),
        .i_ctl  (ctl),
        .o_prod (prod),
        .o_acc  (acc)
    );

    always_comb begin
        // biquad output: double the accumulator, then saturate
        acc_shl = acc <<< 1;
        if ((&acc_shl[A-1:F]) || !(|acc_shl[A-1:F])) begin
            y_sat = acc_shl[W-1:0];
        end else begin
            y_sat = acc_shl[A-1] ? FMIN : FMAX;
        end
        c_sum = (A'(r_sl) + A'(r_sr)) <<< 2;
        l_dif = (A'(r_sl) - A'(r_sr)) <<< 2;
        priority if (c_sum > LIM_HI) c_lim = K_LIMIT;
        else if (c_sum < LIM_LO)     c_lim = -K_LIMIT;
        else                         c_lim = c_sum[W-1:0];
        priority if (l_dif > LIM_HI) l_lim = K_LIMIT;
        else if (l_dif < LIM_LO)     l_lim = -K_LIMIT;
        else                         l_lim = l_dif[W-1:0];
    end

    // sequencer, config and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_mode   <= 2'd0;
            r_enable <= 1'b1;
            r_busy   <= 1'b0;
            r_byp    <= 1'b0;
            r_ov     <= 1'b0;
            r_step   <= S_MUL_LO;
            r_hx0 <= '0; r_hx1 <= '0; r_hy0 <= '0; r_hy1 <= '0;
            r_lx0 <= '0; r_lx1 <= '0; r_ly0 <= '0; r_ly1 <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAIN:   r_gain   <= i_cfg_data;
                    CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    default:    ;
                endcase
            end
            if (in_acc) begin
                r_busy <= 1'b1;
                r_byp  <= !r_enable;
                r_step <= r_enable ? S_MUL_LO : S_DONE;
            end else if (fin) begin
                r_busy <= 1'b0;
                r_step <= S_MUL_LO;
            end else if (r_busy && r_step != S_DONE) begin
                r_step <= n_step;
            end
            if (fin) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (r_busy && r_step == S_LB1) begin
                r_hx1 <= r_hx0; r_hx0 <= r_hx;
                r_hy1 <= r_hy0; r_hy0 <= y_sat;
            end
            if (fin && !r_byp && r_mode[0]) begin
                r_lx1 <= r_lx0; r_lx0 <= r_lx;
                r_ly1 <= r_ly0; r_ly0 <= y_sat;
            end
        end
    end

    // beat payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lin <= i_left_in;
            r_rin <= i_right_in;
        end
        if (r_busy) begin
            unique case (r_step)
                S_MUL_RO: r_lo <= prod;
                S_MUL_SL: begin
                    r_ro <= prod;
                    r_hx <= (r_lo == FMIN) ? FMAX : -r_lo;
                end
                S_MUL_SR: begin
                    r_sl <= prod;
                    r_rs <= (r_ro == FMIN) ? FMAX : -r_ro;
                end
                S_HB0:    r_sr <= prod;
                S_HB1: begin
                    r_c  <= c_lim;
                    r_lx <= l_lim;
                end
                S_LB1:    r_ls <= y_sat;
                default:  ;
            endcase
        end
        if (fin) begin
            if (r_byp) begin
                r_o_l   <= r_lin;
                r_o_r   <= r_rin;
                r_o_ls  <= '0;
                r_o_rs  <= '0;
                r_o_c   <= '0;
                r_o_lfe <= '0;
            end else begin
                r_o_l   <= 32'(r_lo) <<< IO;
                r_o_r   <= 32'(r_ro) <<< IO;
                r_o_ls  <= 32'(r_ls) <<< IO;
                r_o_rs  <= 32'(r_rs) <<< IO;
                r_o_c   <= r_mode[1] ? 32'(r_c) <<< IO : '0;
                r_o_lfe <= r_mode[0] ? 32'(y_sat) <<< IO : '0;
            end
        end
    end

    assign o_valid              = r_ov;
    assign o_left_out           = r_o_l;
    assign o_right_out          = r_o_r;
    assign o_left_surround_out  = r_o_ls;
    assign o_right_surround_out = r_o_rs;
    assign o_center_out         = r_o_c;
    assign o_lfe_out            = r_o_lfe;

    `include "stereo_to_surround_upmix_assert.svh"

    `STSU_ASSERT_NXT(a_accept_busy, in_acc, r_busy)
    `STSU_ASSERT_NXT(a_run_holds, r_busy && r_step != S_DONE, r_busy)
    `STSU_ASSERT_NXT(a_finish_shows, fin, o_valid && !r_busy)
    `STSU_ASSERT_IMP(a_idle_step, !r_busy, r_step == S_MUL_LO)

endmodule
